// ===== rtl/vuhs_pkg.sv =====
// Package for the vector unit hazard scoreboard: commands, register indexes,
// control structs between the top level, the lanes and the merge stage, and helpers.
// No dependencies.
`default_nettype none

package vuhs_pkg;

    localparam int MASK_W     = 48;
    localparam int LANE_GROUP = 8;
    localparam int MINII_BYPASS = 2;
    localparam int RESET_CYCLE_OFS = 10;

    typedef enum logic [1:0] {
        CMD_QUERY  = 2'd0,
        CMD_MANUAL = 2'd1,
        CMD_RECORD = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    localparam logic [1:0] REG_FLAG_LAT  = 2'd0;
    localparam logic [1:0] REG_LOAD_RDY  = 2'd1;
    localparam logic [1:0] REG_BR_ILOCK  = 2'd2;

    localparam logic [3:0] FLAG_LAT_RST = 4'd4;

    localparam int RES_Q      = 0;
    localparam int RES_P      = 1;
    localparam int RES_MAC    = 2;
    localparam int RES_CLIP   = 3;
    localparam int RES_BRANCH = 4;
    localparam int RES_LOAD   = 5;

    typedef struct packed {
        logic sample;
        logic query;
        logic manual;
        logic branch_skip;
        logic write;
        logic clear;
    } lane_ctl_t;

    typedef struct packed {
        logic grp_en;
        logic fin_en;
    } merge_ctl_t;

    // Clamps a signed gap to the 0..255 range of the stall output.
    function automatic logic [7:0] sat8(input logic signed [33:0] v);
        logic [7:0] r;
        if (v < 34'sd0)
            r = 8'd0;
        else if (v > 34'sd255)
            r = 8'd255;
        else
            r = v[7:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vuhs_lane.sv =====
// One scoreboard lane: the entry of one register and its ready-gap check.
// Depends on vuhs_pkg.
`default_nettype none

module vuhs_lane #(
    parameter int CYCLE_BITS = 16,
    parameter bit IS_FLOAT   = 1'b0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  vuhs_pkg::lane_ctl_t     ctl,
    input  logic                    rd_bit,
    input  logic                    mtir_bit,
    input  logic                    ftoi_bit,
    input  logic                    minii_bit,
    input  logic [CYCLE_BITS-1:0]   cur,
    input  logic [CYCLE_BITS-1:0]   ready_new,
    input  logic [3:0]              class_new,
    input  logic [3:0]              bypass_new,
    output logic [7:0]              gap
);
    import vuhs_pkg::*;

    localparam int EXT = 34 - CYCLE_BITS;

    logic [CYCLE_BITS-1:0] ready_reg;
    logic                  tracked_reg;
    logic [3:0]            class_reg;
    logic [3:0]            bypass_reg;
    logic [7:0]            gap_reg;

    logic [5:0]            adj;
    logic [CYCLE_BITS-1:0] diff;
    logic signed [33:0]    diff_ext;
    logic                  use_entry;
    logic [7:0]            gap_next;

    always_comb
    begin
        adj = 6'd0;
        if (class_reg[0] && mtir_bit)
            adj = adj + {2'b00, bypass_reg};
        if (class_reg[1] && ftoi_bit)
            adj = adj + {2'b00, bypass_reg};
        if (class_reg[2] && minii_bit)
            adj = adj + 6'(MINII_BYPASS);
        diff      = ready_reg - cur - {{(CYCLE_BITS-6){1'b0}}, adj};
        diff_ext  = {{EXT{diff[CYCLE_BITS-1]}}, diff};
        // A manual query skips float registers, and branch-interlocked producers
        // when the hardware interlock covers a branch consumer.
        use_entry = rd_bit && tracked_reg && !(ctl.manual && IS_FLOAT)
                    && !(ctl.manual && ctl.branch_skip && class_reg[3]);
        gap_next  = use_entry ? sat8(diff_ext) : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracked_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            tracked_reg <= 1'b0;
        end
        else if (ctl.write && rd_bit)
        begin
            tracked_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.write && rd_bit)
        begin
            ready_reg  <= ready_new;
            class_reg  <= class_new;
            bypass_reg <= bypass_new;
        end
        if (ctl.sample)
        begin
            gap_reg <= ctl.query ? gap_next : 8'd0;
        end
    end

    assign gap = gap_reg;

endmodule

`default_nettype wire

// ===== rtl/vuhs_merge.sv =====
// Merge stage: a two-level registered maximum over the lane gaps and the
// resource gap. Depends on vuhs_pkg.
`default_nettype none

module vuhs_merge #(
    parameter int NLANES = 48
) (
    input  logic                  clk,
    input  vuhs_pkg::merge_ctl_t  ctl,
    input  logic [7:0]            lane_gap [NLANES],
    input  logic [7:0]            scalar_gap,
    output logic [7:0]            stall
);
    import vuhs_pkg::*;

    localparam int NGROUPS = (NLANES + LANE_GROUP - 1) / LANE_GROUP;

    logic [7:0] gap_pad  [NGROUPS*LANE_GROUP];
    logic [7:0] grp_reg  [NGROUPS];
    logic [7:0] grp_next [NGROUPS];
    logic [7:0] stall_reg;
    logic [7:0] stall_next;

    for (genvar k = 0; k < NGROUPS*LANE_GROUP; k++)
    begin : g_pad
        if (k < NLANES)
        begin : g_lane
            assign gap_pad[k] = lane_gap[k];
        end
        else
        begin : g_zero
            assign gap_pad[k] = 8'd0;
        end
    end

    always_comb
    begin
        for (int g = 0; g < NGROUPS; g++)
        begin
            grp_next[g] = 8'd0;
            for (int j = 0; j < LANE_GROUP; j++)
            begin
                if (gap_pad[g*LANE_GROUP+j] > grp_next[g])
                    grp_next[g] = gap_pad[g*LANE_GROUP+j];
            end
        end
    end

    always_comb
    begin
        stall_next = scalar_gap;
        for (int g = 0; g < NGROUPS; g++)
        begin
            if (grp_reg[g] > stall_next)
                stall_next = grp_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.grp_en)
        begin
            for (int g = 0; g < NGROUPS; g++)
                grp_reg[g] <= grp_next[g];
        end
        if (ctl.fin_en)
        begin
            stall_reg <= stall_next;
        end
    end

    assign stall = stall_reg;

endmodule

`default_nettype wire

// ===== rtl/vector_unit_hazard_scoreboard_core.sv =====
// Vector unit hazard scoreboard, top level: command port, configuration port,
// resource cycles, one lane per register (up to 48) and the merge stage. Uses vuhs_pkg,
// vuhs_lane and vuhs_merge.
// done is registered after the lane stage, the group maximum and the final
// maximum, and is high for one cycle; the receiver cannot stall. A new item is
// accepted only while busy is low, once the lane and group stages are empty.
// Reset (rst_n, asynchronous, active low) clears every tracked bit, sets the
// Q, P, MAC and clip cycles to minus ten and the registers to their defaults.
`default_nettype none

module vector_unit_hazard_scoreboard_core #(
    parameter int FLOAT_REGS = 32,
    parameter int INT_REGS   = 16,
    parameter int CYCLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic signed [15:0] cycle,
    input  logic [47:0] reg_mask,
    input  logic [47:0] mtir_read_mask,
    input  logic [47:0] ftoi_read_mask,
    input  logic [47:0] minii_read_mask,
    input  logic [5:0]  resource_bits,
    input  logic [3:0]  producer_latency,
    input  logic [3:0]  producer_class,
    input  logic [3:0]  bypass_amount,
    output logic        done,
    output logic [7:0]  stall_cycles,
    output logic signed [15:0] q_ready,
    output logic signed [15:0] p_ready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vuhs_pkg::*;

    localparam int NREGS  = FLOAT_REGS + INT_REGS;
    localparam int NLANES = (NREGS > MASK_W) ? MASK_W : NREGS;
    localparam int EXT    = 34 - CYCLE_BITS;
    localparam logic [CYCLE_BITS-1:0] CYCLE_RST = '0 - CYCLE_BITS'(RESET_CYCLE_OFS);

    // Configuration registers
    logic [3:0] flag_lat_reg;
    logic [3:0] load_rdy_reg;
    logic       br_ilock_reg;
    logic       cfg_wr;

    // Resource cycles
    logic [CYCLE_BITS-1:0] q_cycle_reg, q_cycle_next;
    logic [CYCLE_BITS-1:0] p_cycle_reg, p_cycle_next;
    logic [CYCLE_BITS-1:0] mac_cycle_reg, mac_cycle_next;
    logic [CYCLE_BITS-1:0] clip_cycle_reg, clip_cycle_next;

    // Pipeline control
    logic s1_valid_reg, s2_valid_reg, done_reg;
    logic accept;
    cmd_t cmd;
    logic is_query, is_record, is_clear, wr_en;

    logic [33:0]           cyc_ext;
    logic [CYCLE_BITS-1:0] cur;
    logic [CYCLE_BITS-1:0] ready_new;
    logic [4:0]            lat_plus1;

    logic [CYCLE_BITS-1:0] q_diff, p_diff, mac_age, clip_age;
    logic signed [33:0]    flat_ext, mac_term, clip_term;
    logic [7:0]            q_gap, p_gap, mac_gap, clip_gap;
    logic [7:0]            scalar_gap_reg, scalar_gap_next;

    logic [33:0]           q_ext, p_ext;

    lane_ctl_t  lane_ctl;
    merge_ctl_t merge_ctl;
    logic [7:0] lane_gap [NLANES];

    assign accept = start && !busy;
    assign busy   = s1_valid_reg || s2_valid_reg;
    assign cmd    = cmd_t'(command);

    always_comb
    begin
        is_query  = 1'b0;
        is_record = 1'b0;
        is_clear  = 1'b0;
        case (cmd)
            CMD_QUERY:  is_query  = 1'b1;
            CMD_MANUAL: is_query  = 1'b1;
            CMD_RECORD: is_record = 1'b1;
            CMD_CLEAR:  is_clear  = 1'b1;
            default:    is_clear  = 1'b0;
        endcase
    end

    assign wr_en   = is_record && (producer_latency > 4'd1);
    assign cyc_ext = {{18{cycle[15]}}, cycle};
    assign cur     = cyc_ext[CYCLE_BITS-1:0];

    // Ready cycle of a record, with the calibrated clamp for plain loads.
    assign lat_plus1 = {1'b0, producer_latency} + 5'd1;
    always_comb
    begin
        if (load_rdy_reg != 4'd0 && resource_bits[RES_LOAD]
            && {1'b0, load_rdy_reg} < lat_plus1)
            ready_new = cur + {{(CYCLE_BITS-4){1'b0}}, load_rdy_reg};
        else
            ready_new = cur + {{(CYCLE_BITS-5){1'b0}}, lat_plus1};
    end

    // Resource gaps. The flag delay stacked on top of the register stall
    // reduces to the larger of the two, so each flag term is a candidate.
    always_comb
    begin
        q_diff    = q_cycle_reg - cur;
        p_diff    = p_cycle_reg - cur;
        mac_age   = cur - mac_cycle_reg;
        clip_age  = cur - clip_cycle_reg;
        flat_ext  = {30'd0, flag_lat_reg};
        mac_term  = flat_ext - {{EXT{mac_age[CYCLE_BITS-1]}}, mac_age};
        clip_term = flat_ext - {{EXT{clip_age[CYCLE_BITS-1]}}, clip_age};
        q_gap     = resource_bits[RES_Q]
                    ? sat8({{EXT{q_diff[CYCLE_BITS-1]}}, q_diff}) : 8'd0;
        p_gap     = resource_bits[RES_P]
                    ? sat8({{EXT{p_diff[CYCLE_BITS-1]}}, p_diff}) : 8'd0;
        mac_gap   = resource_bits[RES_MAC] ? sat8(mac_term) : 8'd0;
        clip_gap  = resource_bits[RES_CLIP] ? sat8(clip_term) : 8'd0;
        scalar_gap_next = q_gap;
        if (p_gap > scalar_gap_next)
            scalar_gap_next = p_gap;
        if (mac_gap > scalar_gap_next)
            scalar_gap_next = mac_gap;
        if (clip_gap > scalar_gap_next)
            scalar_gap_next = clip_gap;
        if (!is_query)
            scalar_gap_next = 8'd0;
    end

    always_comb
    begin
        q_cycle_next    = q_cycle_reg;
        p_cycle_next    = p_cycle_reg;
        mac_cycle_next  = mac_cycle_reg;
        clip_cycle_next = clip_cycle_reg;
        if (accept && is_clear)
        begin
            q_cycle_next    = CYCLE_RST;
            p_cycle_next    = CYCLE_RST;
            mac_cycle_next  = CYCLE_RST;
            clip_cycle_next = CYCLE_RST;
        end
        else if (accept && is_record)
        begin
            if (resource_bits[RES_BRANCH] || resource_bits[RES_MAC])
                mac_cycle_next = cur;
            if (resource_bits[RES_CLIP])
                clip_cycle_next = cur;
            if (wr_en && resource_bits[RES_Q])
                q_cycle_next = ready_new;
            if (wr_en && resource_bits[RES_P])
                p_cycle_next = ready_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cycle_reg    <= CYCLE_RST;
            p_cycle_reg    <= CYCLE_RST;
            mac_cycle_reg  <= CYCLE_RST;
            clip_cycle_reg <= CYCLE_RST;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            q_cycle_reg    <= q_cycle_next;
            p_cycle_reg    <= p_cycle_next;
            mac_cycle_reg  <= mac_cycle_next;
            clip_cycle_reg <= clip_cycle_next;
            s1_valid_reg   <= accept;
            s2_valid_reg   <= s1_valid_reg;
            done_reg       <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scalar_gap_reg <= scalar_gap_next;
        end
    end

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_lat_reg <= FLAG_LAT_RST;
            load_rdy_reg <= 4'd0;
            br_ilock_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_FLAG_LAT: flag_lat_reg <= pwdata[3:0];
                REG_LOAD_RDY: load_rdy_reg <= pwdata[3:0];
                REG_BR_ILOCK: br_ilock_reg <= pwdata[0];
                default:      flag_lat_reg <= flag_lat_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FLAG_LAT: prdata = {28'd0, flag_lat_reg};
            REG_LOAD_RDY: prdata = {28'd0, load_rdy_reg};
            REG_BR_ILOCK: prdata = {31'd0, br_ilock_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // Lanes
    always_comb
    begin
        lane_ctl.sample      = accept;
        lane_ctl.query       = is_query;
        lane_ctl.manual      = (cmd == CMD_MANUAL);
        lane_ctl.branch_skip = br_ilock_reg && resource_bits[RES_BRANCH];
        lane_ctl.write       = accept && wr_en;
        lane_ctl.clear       = accept && is_clear;
    end

    for (genvar i = 0; i < NLANES; i++)
    begin : g_lane
        vuhs_lane #(
            .CYCLE_BITS (CYCLE_BITS),
            .IS_FLOAT   (i < FLOAT_REGS)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (lane_ctl),
            .rd_bit     (reg_mask[i]),
            .mtir_bit   (mtir_read_mask[i]),
            .ftoi_bit   (ftoi_read_mask[i]),
            .minii_bit  (minii_read_mask[i]),
            .cur        (cur),
            .ready_new  (ready_new),
            .class_new  (producer_class),
            .bypass_new (bypass_amount),
            .gap        (lane_gap[i])
        );
    end

    assign merge_ctl.grp_en = s1_valid_reg;
    assign merge_ctl.fin_en = s2_valid_reg;

    vuhs_merge #(
        .NLANES (NLANES)
    ) u_merge (
        .clk        (clk),
        .ctl        (merge_ctl),
        .lane_gap   (lane_gap),
        .scalar_gap (scalar_gap_reg),
        .stall      (stall_cycles)
    );

    // Outputs
    assign done    = done_reg;
    assign q_ext   = {{EXT{q_cycle_reg[CYCLE_BITS-1]}}, q_cycle_reg};
    assign p_ext   = {{EXT{p_cycle_reg[CYCLE_BITS-1]}}, p_cycle_reg};
    assign q_ready = q_ext[15:0];
    assign p_ready = p_ext[15:0];

endmodule

`default_nettype wire

// ===== rtl/vuhs_checker.sv =====
// Port-level checks on the scoreboard's command handshake, bound to the top
// level. Depends on vector_unit_hazard_scoreboard_core.
`default_nettype none

module vuhs_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##3 done)
        else $error("result strobe missing three cycles after accept");

    a_idle_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy high while a result is shown");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

bind vector_unit_hazard_scoreboard_core vuhs_checker u_vuhs_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire
